FILE: sv/wpvs_pkg.sv
package wpvs_pkg;

  localparam int unsigned LENGTH_BITS = 32;
  localparam int unsigned GAIN_BITS   = 17;

  localparam logic [GAIN_BITS-1:0]   UNITY_GAIN  = 17'd65536;
  localparam logic [GAIN_BITS-1:0]   BYPASS_GAIN = 17'd65470;
  localparam logic [LENGTH_BITS-1:0] MIN_FILE    = LENGTH_BITS'(44);
  localparam logic [LENGTH_BITS-1:0] RIFF_HEAD   = LENGTH_BITS'(12);
  localparam logic [31:0]            TAG_FMT     = 32'h666D7420;
  localparam logic [31:0]            TAG_DATA    = 32'h64617461;
  localparam logic [15:0]            FMT_PCM     = 16'd1;
  localparam logic [15:0]            FMT_FLOAT   = 16'd3;
  localparam logic [15:0]            BITS_8      = 16'd8;
  localparam logic [15:0]            BITS_16     = 16'd16;
  localparam logic [31:0]            FMT_MIN_LEN = 32'd16;

  // Configuration register indexes
  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_FLEN = 1'b1;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_HEAD,
    PH_BODY,
    PH_PCM,
    PH_PASS
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_S8,
    KIND_S16
  } kind_e;

  // One parsed byte on its way to the gain stage
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] low;
    logic       last_cur;
    logic       last_prev;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } entry_t;

endpackage

FILE: sv/wpvs_if.sv
interface wpvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface wpvs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

FILE: sv/wpvs_parser.sv
module wpvs_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [7:0]                          byte_i,
  input  logic [wpvs_pkg::GAIN_BITS-1:0]      gain_i,
  input  logic [wpvs_pkg::LENGTH_BITS-1:0]    flen_i,
  output wpvs_pkg::item_t                     item_o
);

  wpvs_pkg::phase_e                  phase_q, phase_d;
  logic [wpvs_pkg::LENGTH_BITS-1:0]  pos_q, pos_d;
  logic [31:0]                       tag_q, tag_d;
  logic [31:0]                       clen_q, clen_d;
  logic [32:0]                       left_q, left_d;
  logic [15:0]                       fmt_q, fmt_d;
  logic [15:0]                       bits_q, bits_d;
  logic [7:0]                        held_q, held_d;
  wpvs_pkg::item_t                   item_q;

  wpvs_pkg::kind_e kind;
  logic            emit;
  logic            last_cur;
  logic            last_prev;
  logic            end_seen;
  logic            parity;
  logic            data_ok;
  logic [33:0]     body_end;
  logic [32:0]     body_at;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q + 1'b1;
    tag_d    = tag_q;
    clen_d   = clen_q;
    left_d   = left_q;
    fmt_d    = fmt_q;
    bits_d   = bits_q;
    held_d   = held_q;
    kind     = wpvs_pkg::KIND_PASS;
    emit     = 1'b1;
    parity   = clen_q[0] ^ left_q[0];
    body_at  = {1'b0, clen_q} + {32'd0, clen_q[0]} - left_q;
    last_cur  = (flen_i != '0) && (pos_q == flen_i - 1'b1);
    last_prev = (flen_i != '0) && (pos_q == flen_i);
    body_end = '0;
    data_ok  = 1'b0;

    unique case (phase_q)
      wpvs_pkg::PH_RIFF: begin
        if (pos_q >= wpvs_pkg::RIFF_HEAD - 1'b1) begin
          phase_d = wpvs_pkg::PH_HEAD;
          left_d  = '0;
        end
      end
      wpvs_pkg::PH_HEAD: begin
        if (left_q < 33'd4) begin
          tag_d = {tag_q[23:0], byte_i};
        end else begin
          clen_d = {byte_i, clen_q[31:8]};
        end
        left_d = left_q + 1'b1;
        if (left_q >= 33'd7) begin
          body_end = 34'(pos_q) + 34'd1 + 34'(clen_d);
          data_ok  = (clen_d != '0)
                     && (fmt_q == wpvs_pkg::FMT_PCM || fmt_q == wpvs_pkg::FMT_FLOAT)
                     && (bits_q == wpvs_pkg::BITS_8 || bits_q == wpvs_pkg::BITS_16)
                     && (flen_i >= wpvs_pkg::MIN_FILE)
                     && (gain_i < wpvs_pkg::BYPASS_GAIN);
          left_d = '0;
          if (body_end > 34'(flen_i)) begin
            phase_d = wpvs_pkg::PH_PASS;
          end else if (tag_d == wpvs_pkg::TAG_DATA) begin
            if (data_ok) begin
              left_d  = {1'b0, clen_d};
              phase_d = wpvs_pkg::PH_PCM;
            end else begin
              phase_d = wpvs_pkg::PH_PASS;
            end
          end else begin
            // body plus pad byte to even length
            left_d  = {1'b0, clen_d} + {32'd0, clen_d[0]};
            phase_d = (left_d != '0) ? wpvs_pkg::PH_BODY : wpvs_pkg::PH_HEAD;
          end
        end
      end
      wpvs_pkg::PH_BODY: begin
        if (tag_q == wpvs_pkg::TAG_FMT && clen_q >= wpvs_pkg::FMT_MIN_LEN) begin
          if (body_at == 33'd0) begin
            fmt_d[7:0] = byte_i;
          end else if (body_at == 33'd1) begin
            fmt_d[15:8] = byte_i;
          end else if (body_at == 33'd14) begin
            bits_d[7:0] = byte_i;
          end else if (body_at == 33'd15) begin
            bits_d[15:8] = byte_i;
          end
        end
        left_d = left_q - 1'b1;
        if (left_q == 33'd1) begin
          phase_d = wpvs_pkg::PH_HEAD;
        end
      end
      wpvs_pkg::PH_PCM: begin
        if (bits_q == wpvs_pkg::BITS_8) begin
          kind = wpvs_pkg::KIND_S8;
        end else if (left_q == 33'd1 && !parity) begin
          // odd trailing byte passes unchanged
          kind = wpvs_pkg::KIND_PASS;
        end else if (!parity) begin
          // hold the low byte until its high byte arrives
          held_d = byte_i;
          emit   = 1'b0;
        end else begin
          kind = wpvs_pkg::KIND_S16;
        end
        left_d = left_q - 1'b1;
        if (left_q == 33'd1) begin
          phase_d = wpvs_pkg::PH_PASS;
        end
      end
      wpvs_pkg::PH_PASS: begin
        emit = 1'b1;
      end
      default: begin
        phase_d = wpvs_pkg::PH_PASS;
      end
    endcase

    end_seen = emit && (last_cur || (kind == wpvs_pkg::KIND_S16 && last_prev));
    if (end_seen) begin
      phase_d = wpvs_pkg::PH_RIFF;
      pos_d   = '0;
      tag_d   = '0;
      clen_d  = '0;
      left_d  = '0;
      fmt_d   = '0;
      bits_d  = '0;
      held_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wpvs_pkg::PH_RIFF;
      pos_q   <= '0;
      tag_q   <= '0;
      clen_q  <= '0;
      left_q  <= '0;
      fmt_q   <= '0;
      bits_q  <= '0;
      held_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      tag_q   <= tag_d;
      clen_q  <= clen_d;
      left_q  <= left_d;
      fmt_q   <= fmt_d;
      bits_q  <= bits_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else begin
      item_q.valid <= accept_i && emit;
      if (accept_i) begin
        item_q.kind      <= kind;
        item_q.data      <= byte_i;
        item_q.low       <= held_q;
        item_q.last_cur  <= last_cur;
        item_q.last_prev <= last_prev;
      end
    end
  end

  assign item_o = item_q;

endmodule

FILE: sv/wpvs_out_fifo.sv
module wpvs_out_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        push_i,
  input  wpvs_pkg::entry_t                  ent0_i,
  input  wpvs_pkg::entry_t                  ent1_i,
  input  logic                              pop_i,
  output wpvs_pkg::entry_t                  head_o,
  output logic [wpvs_pkg::CNT_BITS-1:0]     count_o
);

  wpvs_pkg::entry_t                    mem_q [wpvs_pkg::FIFO_DEPTH];
  logic [wpvs_pkg::PTR_BITS-1:0]       wr_q, rd_q;
  logic [wpvs_pkg::PTR_BITS-1:0]       wr_next;
  logic [wpvs_pkg::CNT_BITS-1:0]       count_q;

  assign wr_next = wr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_i != 2'd0) begin
      mem_q[wr_q] <= ent0_i;
    end
    if (push_i == 2'd2) begin
      mem_q[wr_next] <= ent1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + wpvs_pkg::PTR_BITS'(push_i);
      rd_q    <= rd_q + wpvs_pkg::PTR_BITS'(pop_i);
      count_q <= count_q + wpvs_pkg::CNT_BITS'(push_i) - wpvs_pkg::CNT_BITS'(pop_i);
    end
  end

  assign head_o  = mem_q[rd_q];
  assign count_o = count_q;

endmodule

FILE: sv/wav_pcm_volume_scaler_top.sv
// WAV PCM volume scaler.
// Bytes of a WAV file enter on in_ch, one request per byte, in file order, and
// leave on out_ch in the same order, each flagged last_byte at the final file
// position. Samples of the first accepted data chunk (format 1 or 3, 8 or 16
// bits) are multiplied by the Q16 gain; everything else passes unchanged.
// Write gain and file length on the cfg port before streaming a file.
// A passed or 8-bit byte is registered in the parser's item register and then written
// into the output queue before it appears on out_ch. A 16-bit low byte is held and
// leaves together with its high byte, as two consecutive results.
// Throughput: one byte per cycle unless stalled. The parser takes each accepted byte;
// the gain multiplier produces up to two result bytes per cycle into an eight-entry
// output queue that drains one byte per cycle while out_ch.ready is high.
// A stalled receiver fills the queue; in_ch.ready drops while fewer than two
// free entries remain beyond those already promised to the gain stage.
// Reset clears the parser, empties the queue and sets gain to unity and file
// length to zero. After the last byte of a file the parser returns to its
// reset state, ready for the next file; configuration is kept.
module wav_pcm_volume_scaler_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [31:0]                         cfg_wdata_i,
  wpvs_in_if.sink                             in_ch,
  wpvs_out_if.source                          out_ch
);

  logic [wpvs_pkg::GAIN_BITS-1:0]    gain_q;
  logic [wpvs_pkg::LENGTH_BITS-1:0]  flen_q;

  logic                              in_accept;
  wpvs_pkg::item_t                   item;
  logic [wpvs_pkg::CNT_BITS-1:0]     count;
  logic [wpvs_pkg::CNT_BITS:0]       committed;

  logic [wpvs_pkg::GAIN_BITS-1:0]    gain_eff;
  logic [15:0]                       sample;
  logic                              neg;
  logic [15:0]                       mag;
  logic [32:0]                       prod;
  logic [15:0]                       res;
  logic [1:0]                        push;
  wpvs_pkg::entry_t                  ent0, ent1, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= wpvs_pkg::UNITY_GAIN;
      flen_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wpvs_pkg::REG_GAIN: gain_q <= cfg_wdata_i[wpvs_pkg::GAIN_BITS-1:0];
        wpvs_pkg::REG_FLEN: flen_q <= cfg_wdata_i[wpvs_pkg::LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Queue entries plus two for the byte in the gain stage must leave room for two more
  assign committed = {1'b0, count} + (item.valid ? 5'd2 : 5'd0);
  assign in_ch.ready = committed <= 5'(wpvs_pkg::FIFO_DEPTH - 2);
  assign in_accept   = in_ch.valid && in_ch.ready;

  wpvs_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (in_ch.in_byte),
    .gain_i   (gain_q),
    .flen_i   (flen_q),
    .item_o   (item)
  );

  // Gain at most unity, so the truncated product always fits the sample range
  assign gain_eff = gain_q[wpvs_pkg::GAIN_BITS-1] ? wpvs_pkg::UNITY_GAIN : gain_q;
  assign sample   = (item.kind == wpvs_pkg::KIND_S16) ? {item.data, item.low}
                  : {{8{~item.data[7]}}, ~item.data[7], item.data[6:0]};
  assign neg      = sample[15];
  assign mag      = neg ? (16'd0 - sample) : sample;
  assign prod     = {17'd0, mag} * {16'd0, gain_eff};
  assign res      = neg ? (16'd0 - prod[31:16]) : prod[31:16];

  always_comb begin
    push = 2'd0;
    ent0 = '{data: item.data, last: item.last_cur};
    ent1 = '{data: res[15:8], last: item.last_cur};
    if (item.valid) begin
      unique case (item.kind)
        wpvs_pkg::KIND_PASS: begin
          push = 2'd1;
        end
        wpvs_pkg::KIND_S8: begin
          push = 2'd1;
          ent0 = '{data: res[7:0] ^ 8'h80, last: item.last_cur};
        end
        wpvs_pkg::KIND_S16: begin
          push = 2'd2;
          ent0 = '{data: res[7:0], last: item.last_prev};
        end
        default: begin
          push = 2'd1;
        end
      endcase
    end
  end

  wpvs_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent0_i  (ent0),
    .ent1_i  (ent1),
    .pop_i   (out_ch.valid && out_ch.ready),
    .head_o  (head),
    .count_o (count)
  );

  assign out_ch.valid     = count != '0;
  assign out_ch.out_byte  = head.data;
  assign out_ch.last_byte = head.last;

endmodule

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] TAG_RIFF     = 32'h52494646;
  localparam logic [31:0] TAG_WAVE     = 32'h57415645;
  localparam logic [31:0] TAG_LIST     = 32'h4C495354;
  localparam logic [15:0] FMT_ADPCM    = 16'd2;
  localparam logic [15:0] BITS_24      = 16'd24;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          RANDOM_BYTES = 300;
  localparam int          WATCHDOG_NS  = 10_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  wpvs_in_if  in_ch ();
  wpvs_out_if out_ch ();

  wav_pcm_volume_scaler_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser mirror and register copies
  logic [wpvs_pkg::GAIN_BITS-1:0]   gain_reg;
  logic [wpvs_pkg::LENGTH_BITS-1:0] flen_reg;
  logic [wpvs_pkg::LENGTH_BITS-1:0] pos;
  wpvs_pkg::phase_e                 phase;
  logic [31:0]                      tag;
  logic [31:0]                      clen;
  logic [32:0]                      left;
  logic [15:0]                      fmt_code;
  logic [15:0]                      sample_bits;
  logic [7:0]                       held_low;

  wpvs_pkg::entry_t expected_bytes[$];
  logic [7:0]       wav[$];
  int               data_at;
  int               errors;
  int               burst_left;
  int               bytes_sent;
  int               rx_mode = 0;
  int               rx_left = 0;
  int unsigned      rx_tick = 0;

  function automatic bit is_final(logic [wpvs_pkg::LENGTH_BITS-1:0] where);
    return flen_reg != 0 && where == flen_reg - 1;
  endfunction

  function automatic int apply_gain(int v, int lo, int hi);
    longint unsigned mag;
    longint unsigned g;
    int r;
    mag = (v < 0) ? -v : v;
    g = (gain_reg > wpvs_pkg::UNITY_GAIN) ? wpvs_pkg::UNITY_GAIN : gain_reg;
    r = int'((mag * g) >> 16);
    if (v < 0) r = -r;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic void clear_parser();
    pos = '0;
    phase = wpvs_pkg::PH_RIFF;
    tag = '0;
    clen = '0;
    left = '0;
    fmt_code = '0;
    sample_bits = '0;
    held_low = '0;
  endfunction

  function automatic void close_header(logic [wpvs_pkg::LENGTH_BITS-1:0] where);
    logic [33:0] body_end;
    body_end = 34'(where) + 34'd1 + 34'(clen);
    left = '0;
    if (body_end > 34'(flen_reg)) begin
      phase = wpvs_pkg::PH_PASS;
    end else if (tag == wpvs_pkg::TAG_DATA) begin
      if (clen != 0 && (fmt_code == wpvs_pkg::FMT_PCM || fmt_code == wpvs_pkg::FMT_FLOAT) &&
          (sample_bits == wpvs_pkg::BITS_8 || sample_bits == wpvs_pkg::BITS_16) &&
          flen_reg >= wpvs_pkg::MIN_FILE && gain_reg < wpvs_pkg::BYPASS_GAIN) begin
        left = 33'(clen);
        phase = wpvs_pkg::PH_PCM;
      end else begin
        phase = wpvs_pkg::PH_PASS;
      end
    end else begin
      left = 33'(clen) + 33'(clen[0]);
      phase = (left != 0) ? wpvs_pkg::PH_BODY : wpvs_pkg::PH_HEAD;
    end
  endfunction

  // Advance the parser mirror by one request and queue the bytes it releases
  function automatic void predict_byte(logic [7:0] b);
    logic [32:0]      at;
    logic [15:0]      raw;
    logic [15:0]      scaled;
    logic [7:0]       o;
    wpvs_pkg::entry_t e;
    int               n;
    bit               even;
    bit               ends;
    o = b;
    n = 1;
    ends = 1'b0;
    case (phase)
      wpvs_pkg::PH_RIFF: begin
        if (pos >= wpvs_pkg::RIFF_HEAD - 1) begin
          phase = wpvs_pkg::PH_HEAD;
          left = '0;
        end
      end
      wpvs_pkg::PH_HEAD: begin
        if (left < 4) tag = {tag[23:0], b};
        else clen = {b, clen[31:8]};
        left++;
        if (left >= 8) close_header(pos);
      end
      wpvs_pkg::PH_BODY: begin
        at = 33'(clen) + 33'(clen[0]) - left;
        if (tag == wpvs_pkg::TAG_FMT && clen >= wpvs_pkg::FMT_MIN_LEN) begin
          case (at)
            0: fmt_code[7:0] = b;
            1: fmt_code[15:8] = b;
            14: sample_bits[7:0] = b;
            15: sample_bits[15:8] = b;
            default: ;
          endcase
        end
        left--;
        if (left == 0) phase = wpvs_pkg::PH_HEAD;
      end
      wpvs_pkg::PH_PCM: begin
        even = (clen[0] ^ left[0]) == 1'b0;
        if (sample_bits == wpvs_pkg::BITS_8) begin
          o = 8'(apply_gain(int'(b) - 128, -128, 127) + 128);
        end else if (left == 1 && even) begin
          o = b;
        end else if (even) begin
          held_low = b;
          n = 0;
        end else begin
          raw = {b, held_low};
          scaled = 16'(apply_gain(int'($signed(raw)), -32768, 32767));
          e.data = scaled[7:0];
          e.last = is_final(pos - 1);
          expected_bytes.push_back(e);
          ends = e.last;
          o = scaled[15:8];
          n = 2;
        end
        left--;
        if (left == 0) phase = wpvs_pkg::PH_PASS;
      end
      default: ;
    endcase
    if (n >= 1) begin
      e.data = o;
      e.last = is_final(pos);
      expected_bytes.push_back(e);
      ends = ends | e.last;
    end
    pos = pos + 1;
    if (ends) clear_parser();
  endfunction

  function automatic void check_result(logic [7:0] got_byte, logic got_last);
    wpvs_pkg::entry_t want;
    if (expected_bytes.size() == 0) begin
      $error("unexpected result: out_byte %02h last_byte %0b", got_byte, got_last);
      errors++;
    end else begin
      want = expected_bytes.pop_front();
      if (got_byte !== want.data) begin
        $error("out_byte mismatch: expected %02h, actual %02h", want.data, got_byte);
        errors++;
      end
      if (got_last !== want.last) begin
        $error("last_byte mismatch: expected %0b, actual %0b", want.last, got_last);
        errors++;
      end
    end
  endfunction

  // Receiver: check each result, then pick ready from the current stall mode
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result(out_ch.out_byte, out_ch.last_byte);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(64, 256);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= (rx_tick % 7) >= 3;
        default: out_ch.ready <= (rx_tick % 16) >= 12;
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 16);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_byte(b);
    bytes_sent++;
  endtask

  // Hold off with in_ch.valid low until every queued byte has been received and checked
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [wpvs_pkg::GAIN_BITS-1:0] gain,
                           input logic [wpvs_pkg::LENGTH_BITS-1:0] flen);
    logic [31-wpvs_pkg::GAIN_BITS:0] junk;
    junk = ($urandom_range(0, 7) == 0) ? (32 - wpvs_pkg::GAIN_BITS)'($urandom) : '0;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= wpvs_pkg::REG_GAIN;
    cfg_wdata_i <= {junk, gain};
    @(posedge clk_i);
    cfg_idx_i <= wpvs_pkg::REG_FLEN;
    cfg_wdata_i <= 32'(flen);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gain_reg = gain;
    flen_reg = flen;
  endtask

  // Finish a file that never reached its last byte: move the end to the next position
  task automatic realign();
    while (pos != 0) begin
      wait_idle();
      write_cfg(gain_reg, pos + 1);
      send_byte(8'($urandom));
    end
  endtask

  function automatic void put_le(logic [31:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) wav.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_tag(logic [31:0] t);
    for (int i = 3; i >= 0; i--) wav.push_back(t[8*i +: 8]);
  endfunction

  function automatic void put_chunk(logic [31:0] t, int len);
    put_tag(t);
    put_le(len, 4);
    for (int i = 0; i < len + len % 2; i++) wav.push_back(8'($urandom));
  endfunction

  function automatic void build_wav(logic [15:0] fmt, logic [15:0] bits, int fmt_len,
                                    int data_len, bit lead_chunk, bit tail_chunk);
    wav.delete();
    put_tag(TAG_RIFF);
    put_le($urandom, 4);
    put_tag(TAG_WAVE);
    if (lead_chunk) put_chunk(TAG_LIST, $urandom_range(0, 9));
    put_tag(wpvs_pkg::TAG_FMT);
    put_le(fmt_len, 4);
    for (int i = 0; i < fmt_len + fmt_len % 2; i++) begin
      case (i)
        0, 1: wav.push_back(fmt[8*i +: 8]);
        14, 15: wav.push_back(bits[8*(i-14) +: 8]);
        default: wav.push_back(8'($urandom));
      endcase
    end
    put_tag(wpvs_pkg::TAG_DATA);
    put_le(data_len, 4);
    data_at = wav.size();
    for (int i = 0; i < data_len + data_len % 2; i++) wav.push_back(8'($urandom));
    if (tail_chunk) put_chunk(TAG_LIST, $urandom_range(0, 9));
  endfunction

  task automatic play_file(input logic [wpvs_pkg::GAIN_BITS-1:0] gain,
                           input logic [wpvs_pkg::LENGTH_BITS-1:0] flen,
                           input int pause_at, input logic [wpvs_pkg::GAIN_BITS-1:0] pause_gain,
                           input int copies);
    int nbytes;
    nbytes = (flen == 0 || flen > wav.size()) ? wav.size() : int'(flen);
    wait_idle();
    write_cfg(gain, flen);
    for (int c = 0; c < copies; c++) begin
      for (int i = 0; i < nbytes; i++) begin
        if (c == 0 && i == pause_at) begin
          wait_idle();
          write_cfg(pause_gain, flen);
        end
        send_byte(wav[i]);
      end
    end
    realign();
  endtask

  task automatic test_pcm8_scaling();
    logic [7:0] corner[7];
    corner = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'h81, 8'hFE, 8'hFF};
    build_wav(wpvs_pkg::FMT_PCM, wpvs_pkg::BITS_8, 16, 9, 1'b0, 1'b0);
    foreach (corner[i]) wav[data_at + i] = corner[i];
    play_file(17'd32768, wav.size(), -1, 17'd32768, 1);
    play_file(17'd0, wav.size(), -1, 17'd0, 1);
  endtask

  task automatic test_pcm16_scaling();
    logic [7:0] corner[11];
    corner = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h34, 8'h12, 8'hAB};
    // odd length: the trailing byte has no partner
    build_wav(wpvs_pkg::FMT_FLOAT, wpvs_pkg::BITS_16, 18, 11, 1'b1, 1'b1);
    foreach (corner[i]) wav[data_at + i] = corner[i];
    play_file(wpvs_pkg::BYPASS_GAIN - 1, wav.size(), -1, wpvs_pkg::BYPASS_GAIN - 1, 1);
    build_wav(wpvs_pkg::FMT_PCM, wpvs_pkg::BITS_16, 16, 10, 1'b0, 1'b0);
    play_file(17'd1, wav.size(), -1, 17'd1, 2);
  endtask

  task automatic test_passthrough_cases();
    build_wav(wpvs_pkg::FMT_PCM, wpvs_pkg::BITS_8, 16, 6, 1'b0, 1'b0);
    play_file(wpvs_pkg::BYPASS_GAIN, wav.size(), -1, wpvs_pkg::BYPASS_GAIN, 1);
    play_file(wpvs_pkg::UNITY_GAIN, wav.size(), -1, wpvs_pkg::UNITY_GAIN, 1);
    play_file(17'h1FFFF, wav.size(), -1, 17'h1FFFF, 1);
    build_wav(FMT_ADPCM, wpvs_pkg::BITS_16, 16, 6, 1'b0, 1'b0);
    play_file(17'd1000, wav.size(), -1, 17'd1000, 1);
    build_wav(wpvs_pkg::FMT_PCM, BITS_24, 16, 6, 1'b0, 1'b0);
    play_file(17'd1000, wav.size(), -1, 17'd1000, 1);
    build_wav(16'h0101, 16'h0108, 16, 6, 1'b0, 1'b0);
    play_file(17'd1000, wav.size(), -1, 17'd1000, 1);
    // fmt chunk too short to carry the format
    build_wav(wpvs_pkg::FMT_PCM, wpvs_pkg::BITS_8, 14, 6, 1'b0, 1'b0);
    play_file(17'd1000, wav.size(), -1, 17'd1000, 1);
    build_wav(wpvs_pkg::FMT_PCM, wpvs_pkg::BITS_8, 16, 0, 1'b0, 1'b1);
    play_file(17'd1000, wav.size(), -1, 17'd1000, 1);
    build_wav(wpvs_pkg::FMT_PCM, wpvs_pkg::BITS_8, 16, 20, 1'b0, 1'b0);
    play_file(17'd1000, 32'd40, -1, 17'd1000, 1);
    play_file(17'd1000, wav.size() - 5, -1, 17'd1000, 1);
  endtask

  task automatic test_gain_change_mid_chunk();
    build_wav(wpvs_pkg::FMT_PCM, wpvs_pkg::BITS_8, 16, 30, 1'b0, 1'b0);
    play_file(17'd40000, wav.size(), data_at + 10, 17'd9000, 1);
    // pause with a low byte held, then raise gain past unity
    build_wav(wpvs_pkg::FMT_PCM, wpvs_pkg::BITS_16, 16, 20, 1'b0, 1'b0);
    play_file(17'd30000, wav.size(), data_at + 5, 17'h1FFFF, 1);
  endtask

  task automatic test_length_extremes();
    build_wav(wpvs_pkg::FMT_PCM, wpvs_pkg::BITS_16, 16, 12, 1'b0, 1'b1);
    play_file(17'd20000, 32'd0, -1, 17'd20000, 1);
    play_file(17'd20000, 32'hFFFF_FFFF, -1, 17'd20000, 1);
  endtask

  task automatic test_random_files();
    logic [15:0]                      fmt;
    logic [15:0]                      bits;
    logic [wpvs_pkg::GAIN_BITS-1:0]   gain;
    logic [wpvs_pkg::GAIN_BITS-1:0]   gain2;
    logic [wpvs_pkg::LENGTH_BITS-1:0] flen;
    int fmt_len, data_len, pick, pause_at, copies;
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: fmt = wpvs_pkg::FMT_PCM;
        5, 6, 7: fmt = wpvs_pkg::FMT_FLOAT;
        8: fmt = FMT_ADPCM;
        default: fmt = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: bits = wpvs_pkg::BITS_8;
        5, 6, 7, 8: bits = wpvs_pkg::BITS_16;
        default: bits = ($urandom_range(0, 1) == 0) ? BITS_24 : 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
        7: fmt_len = 18;
        8: fmt_len = 17;
        9: fmt_len = $urandom_range(0, 40);
        default: fmt_len = 16;
      endcase
      data_len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 200) : $urandom_range(1, 48);
      build_wav(fmt, bits, fmt_len, data_len, $urandom_range(0, 3) == 0,
                $urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: gain = ($urandom_range(0, 1) == 0) ? 17'd0 : wpvs_pkg::BYPASS_GAIN - 1;
        1: gain = 17'($urandom_range(wpvs_pkg::BYPASS_GAIN, wpvs_pkg::UNITY_GAIN));
        2: gain = 17'($urandom);
        default: gain = 17'($urandom_range(0, wpvs_pkg::BYPASS_GAIN - 1));
      endcase
      flen = wav.size();
      pause_at = -1;
      copies = 1;
      gain2 = gain;
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        flen = $urandom_range(1, wav.size() - 1);
      end else if (pick < 4) begin
        // noise: random bytes with a matching length
        wav.delete();
        repeat ($urandom_range(1, 64)) wav.push_back(8'($urandom));
        flen = wav.size();
      end else if (pick < 6) begin
        pause_at = $urandom_range(1, wav.size() - 1);
        gain2 = 17'($urandom_range(0, wpvs_pkg::BYPASS_GAIN - 1));
      end else if (pick < 8) begin
        copies = 2;
      end
      play_file(gain, flen, pause_at, gain2, copies);
    end
  endtask

  initial begin
    errors = 0;
    burst_left = 0;
    bytes_sent = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = wpvs_pkg::REG_GAIN;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    gain_reg = wpvs_pkg::UNITY_GAIN;
    flen_reg = '0;
    clear_parser();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pcm8_scaling();
    test_pcm16_scaling();
    test_passthrough_cases();
    test_gain_change_mid_chunk();
    test_length_extremes();
    test_random_files();

    in_ch.valid <= 1'b0;
    for (int w = 0; w < 5000 && expected_bytes.size() != 0; w++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_bytes.size() != 0) begin
      $error("%0d expected bytes never arrived", expected_bytes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("wav_pcm_volume_scaler_top verification clean");
    end else begin
      $display("wav_pcm_volume_scaler_top verification failed");
    end
    $finish;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("wav_pcm_volume_scaler_top verification failed");
    $finish;
  end

endmodule
